FILE: rtl/core/gpio_pcrb_pkg.sv
package gpio_pcrb_pkg;

    typedef enum logic [2:0] {
        OP_SET_FUNC = 3'd0,
        OP_GET_FUNC = 3'd1,
        OP_SET_PULL = 3'd2,
        OP_GET_PULL = 3'd3,
        OP_SET_DATA = 3'd4,
        OP_GET_DATA = 3'd5
    } op_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_MODIFY = 1'b1
    } state_t;

    localparam int LINE_W   = 5;
    localparam int PORT_MAX = 8;
    localparam int WORD_W   = 32;

    localparam logic [WORD_W-1:0] FUNC_MASK = 32'h0000_0007;
    localparam logic [WORD_W-1:0] PULL_MASK = 32'h0000_0003;
    localparam logic [WORD_W-1:0] DATA_MASK = 32'h0000_0001;

endpackage

FILE: rtl/core/gpio_pin_config_register_bank.sv
// gpio pin configuration register bank
//
// one command channel: a transaction (op, pin, write_data) is taken at the
// rising edge where start is high and busy is low. pin[7:5] picks the port,
// pin[4:0] the line; the access sets or reads the function, pull or data
// field of that line.
// one result per transaction: read_data is valid for exactly one cycle while
// done is high; set operations and unused op codes return zero.
// done is registered out of the modify state. a new command is taken only
// while busy is low, so the block does not take a new transaction before it is
// through with the last. the edge that accepts a command also issues the read
// of the three word memories into registers; the next cycle merges the field
// and writes the word back, with busy high. the following cycle is idle again,
// so no two accesses to one entry overlap.
// reset: all words read as zero through per-entry valid bits cleared at once,
// no clearing pass. the receiver cannot stall; results are never held.
module gpio_pin_config_register_bank #(
    parameter int NUM_PORTS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] op,
    input  logic [7:0] pin,
    input  logic [2:0] write_data,
    output logic       done,
    output logic [2:0] read_data
);

    localparam int FUNC_DEPTH = NUM_PORTS * 4;
    localparam int PULL_DEPTH = NUM_PORTS * 2;
    localparam int DATA_DEPTH = NUM_PORTS;
    localparam int FA_W = $clog2(FUNC_DEPTH);
    localparam int PA_W = $clog2(PULL_DEPTH);
    localparam int DA_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int W    = gpio_pcrb_pkg::WORD_W;

    logic [W-1:0] func_mem [FUNC_DEPTH];
    logic [W-1:0] pull_mem [PULL_DEPTH];
    logic [W-1:0] data_mem [DATA_DEPTH];

    logic [FUNC_DEPTH-1:0] func_vld_reg;
    logic [PULL_DEPTH-1:0] pull_vld_reg;
    logic [DATA_DEPTH-1:0] data_vld_reg;

    gpio_pcrb_pkg::state_t state_reg, state_next;

    logic [2:0]      op_reg;
    logic [4:0]      line_reg;
    logic [2:0]      wd_reg;
    logic            hit_reg;
    logic [FA_W-1:0] fa_reg;
    logic [PA_W-1:0] pa_reg;
    logic [DA_W-1:0] da_reg;

    logic [W-1:0] func_rd_reg, pull_rd_reg, data_rd_reg;
    logic         func_rv_reg, pull_rv_reg, data_rv_reg;

    logic       done_reg, done_next;
    logic [2:0] read_data_reg, read_data_next;

    logic            accept;
    logic [2:0]      port;
    logic            hit;
    logic [4:0]      fa_full;
    logic [3:0]      pa_full;
    logic [FA_W-1:0] fa;
    logic [PA_W-1:0] pa;
    logic [DA_W-1:0] da;

    logic [W-1:0] func_word, pull_word, data_word;
    logic [4:0]   fsh, psh;
    logic         func_we, pull_we, data_we;
    logic [W-1:0] func_wr, pull_wr, data_wr;

    assign accept  = start && (state_reg == gpio_pcrb_pkg::ST_IDLE);
    assign port    = pin[7:5];
    assign hit     = {1'b0, port} < 4'(NUM_PORTS);
    assign fa_full = {port, pin[4:3]};
    assign pa_full = {port, pin[4]};
    assign fa      = fa_full[FA_W-1:0];
    assign pa      = pa_full[PA_W-1:0];
    assign da      = DA_W'(port);

    // memory reads, issued on the accepting edge
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_rd_reg <= func_mem[fa];
            pull_rd_reg <= pull_mem[pa];
            data_rd_reg <= data_mem[da];
            op_reg      <= op;
            line_reg    <= pin[4:0];
            wd_reg      <= write_data;
            fa_reg      <= fa;
            pa_reg      <= pa;
            da_reg      <= da;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg     <= 1'b0;
            func_rv_reg <= 1'b0;
            pull_rv_reg <= 1'b0;
            data_rv_reg <= 1'b0;
        end
        else if (accept)
        begin
            hit_reg     <= hit;
            func_rv_reg <= func_vld_reg[fa];
            pull_rv_reg <= pull_vld_reg[pa];
            data_rv_reg <= data_vld_reg[da];
        end
    end

    // modify stage
    assign func_word = func_rv_reg ? func_rd_reg : '0;
    assign pull_word = pull_rv_reg ? pull_rd_reg : '0;
    assign data_word = data_rv_reg ? data_rd_reg : '0;
    assign fsh       = {line_reg[2:0], 2'b00};
    assign psh       = {line_reg[3:0], 1'b0};

    assign func_wr = (func_word & ~(gpio_pcrb_pkg::FUNC_MASK << fsh))
                   | ((W'(wd_reg) & gpio_pcrb_pkg::FUNC_MASK) << fsh);
    assign pull_wr = (pull_word & ~(gpio_pcrb_pkg::PULL_MASK << psh))
                   | ((W'(wd_reg) & gpio_pcrb_pkg::PULL_MASK) << psh);
    assign data_wr = (data_word & ~(gpio_pcrb_pkg::DATA_MASK << line_reg))
                   | ((W'(wd_reg) & gpio_pcrb_pkg::DATA_MASK) << line_reg);

    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        read_data_next = '0;
        func_we        = 1'b0;
        pull_we        = 1'b0;
        data_we        = 1'b0;
        case (state_reg)
            gpio_pcrb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = gpio_pcrb_pkg::ST_MODIFY;
                end
            end
            gpio_pcrb_pkg::ST_MODIFY:
            begin
                state_next = gpio_pcrb_pkg::ST_IDLE;
                done_next  = 1'b1;
                if (hit_reg)
                begin
                    case (gpio_pcrb_pkg::op_t'(op_reg))
                        gpio_pcrb_pkg::OP_SET_FUNC: func_we = 1'b1;
                        gpio_pcrb_pkg::OP_GET_FUNC:
                            read_data_next = 3'((func_word >> fsh) & gpio_pcrb_pkg::FUNC_MASK);
                        gpio_pcrb_pkg::OP_SET_PULL: pull_we = 1'b1;
                        gpio_pcrb_pkg::OP_GET_PULL:
                            read_data_next = 3'((pull_word >> psh) & gpio_pcrb_pkg::PULL_MASK);
                        gpio_pcrb_pkg::OP_SET_DATA: data_we = 1'b1;
                        gpio_pcrb_pkg::OP_GET_DATA:
                            read_data_next = 3'((data_word >> line_reg)
                                                & gpio_pcrb_pkg::DATA_MASK);
                        default: ;
                    endcase
                end
            end
            default: state_next = gpio_pcrb_pkg::ST_IDLE;
        endcase
    end

    // write back
    always_ff @(posedge clk)
    begin
        if (func_we)
        begin
            func_mem[fa_reg] <= func_wr;
        end
        if (pull_we)
        begin
            pull_mem[pa_reg] <= pull_wr;
        end
        if (data_we)
        begin
            data_mem[da_reg] <= data_wr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gpio_pcrb_pkg::ST_IDLE;
            done_reg      <= 1'b0;
            read_data_reg <= '0;
            func_vld_reg  <= '0;
            pull_vld_reg  <= '0;
            data_vld_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            read_data_reg <= read_data_next;
            if (func_we)
            begin
                func_vld_reg[fa_reg] <= 1'b1;
            end
            if (pull_we)
            begin
                pull_vld_reg[pa_reg] <= 1'b1;
            end
            if (data_we)
            begin
                data_vld_reg[da_reg] <= 1'b1;
            end
        end
    end

    assign busy      = (state_reg == gpio_pcrb_pkg::ST_MODIFY);
    assign done      = done_reg;
    assign read_data = read_data_reg;

endmodule

FILE: rtl/core/gpio_pcrb_checker.sv
module gpio_pcrb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [2:0] op,
    input logic       done,
    input logic [2:0] read_data
);

    // accepted transaction occupies the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // every busy cycle ends in a result
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("no result after busy cycle");

    // no result without a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without transaction");

    // set operations return zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(op, 2) == gpio_pcrb_pkg::OP_SET_FUNC
               || $past(op, 2) == gpio_pcrb_pkg::OP_SET_PULL
               || $past(op, 2) == gpio_pcrb_pkg::OP_SET_DATA)) |-> (read_data == 3'd0))
        else $error("set operation returned nonzero data");

endmodule

bind gpio_pin_config_register_bank gpio_pcrb_checker u_gpio_pcrb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .done      (done),
    .read_data (read_data)
);

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PORTS        = 8;
    localparam int RANDOM_CMDS  = 600;
    localparam int CALM_TAIL    = 60;
    localparam int QUIET_LIMIT  = 400;
    localparam int DRAIN_CYCLES = 8;

    // op codes the block does not decode
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] pin;
        logic [2:0] wdata;
    } gpio_cmd_t;

    typedef struct packed {
        gpio_cmd_t  cmd;
        logic [2:0] rdata;
    } gpio_read_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       start      = 1'b0;
    logic [2:0] op         = '0;
    logic [7:0] pin        = '0;
    logic [2:0] write_data = '0;
    logic       busy;
    logic       done;
    logic [2:0] read_data;

    logic [31:0] func_shadow [PORTS*4];
    logic [31:0] pull_shadow [PORTS*2];
    logic [31:0] data_shadow [PORTS];

    gpio_cmd_t  cmd_queue [$];
    gpio_read_t read_queue [$];

    gpio_cmd_t  next_cmd;
    gpio_read_t read_exp;
    gpio_read_t got_exp;
    logic       next_start;
    int         errors       = 0;
    int         idle_left    = 0;
    int         gap_pct      = 0;
    int         accepted     = 0;
    int         quiet_cycles = 0;

    gpio_pin_config_register_bank #(
        .NUM_PORTS(PORTS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .pin       (pin),
        .write_data(write_data),
        .done      (done),
        .read_data (read_data)
    );

    always #6 clk = ~clk;

    // shadow register file access, returns the expected read_data
    function automatic logic [2:0] gpio_access(input logic [2:0] cmd_op,
                                               input logic [7:0] cmd_pin,
                                               input logic [2:0] value);
        logic [2:0] port;
        logic [4:0] line;
        logic [4:0] fidx;
        logic [4:0] fsh;
        logic [3:0] pidx;
        logic [4:0] psh;
        logic [2:0] rd;
        port = cmd_pin[7:5];
        line = cmd_pin[4:0];
        fidx = {port, line[4:3]};
        fsh  = {line[2:0], 2'b00};
        pidx = {port, line[4]};
        psh  = {line[3:0], 1'b0};
        rd   = '0;
        if (int'(port) < PORTS)
        begin
            case (cmd_op)
                gpio_pcrb_pkg::OP_SET_FUNC: func_shadow[fidx][fsh +: 3] = value;
                gpio_pcrb_pkg::OP_GET_FUNC: rd = func_shadow[fidx][fsh +: 3];
                gpio_pcrb_pkg::OP_SET_PULL: pull_shadow[pidx][psh +: 2] = value[1:0];
                gpio_pcrb_pkg::OP_GET_PULL: rd = {1'b0, pull_shadow[pidx][psh +: 2]};
                gpio_pcrb_pkg::OP_SET_DATA: data_shadow[port][line] = value[0];
                gpio_pcrb_pkg::OP_GET_DATA: rd = {2'b00, data_shadow[port][line]};
                default: ;
            endcase
        end
        return rd;
    endfunction

    task automatic add_cmd(input logic [2:0] c_op, input logic [7:0] c_pin,
                           input logic [2:0] c_wdata);
        gpio_cmd_t c;
        c.op    = c_op;
        c.pin   = c_pin;
        c.wdata = c_wdata;
        cmd_queue.push_back(c);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            idle_left = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                read_exp.cmd   = '{op, pin, write_data};
                read_exp.rdata = gpio_access(op, pin, write_data);
                read_queue.push_back(read_exp);
                accepted++;
                if (accepted % 40 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: gap_pct = 0;
                        1: gap_pct = 15;
                        default: gap_pct = 50;
                    endcase
                end
            end
            if (!start || !busy)
            begin
                next_start = 1'b0;
                if (idle_left > 0)
                begin
                    idle_left--;
                end
                else if (cmd_queue.size() > 0)
                begin
                    if (cmd_queue.size() > CALM_TAIL && $urandom_range(0, 99) < gap_pct)
                    begin
                        idle_left = $urandom_range(1, 12) - 1;
                    end
                    else
                    begin
                        next_cmd   = cmd_queue.pop_front();
                        next_start = 1'b1;
                        op         <= next_cmd.op;
                        pin        <= next_cmd.pin;
                        write_data <= next_cmd.wdata;
                    end
                end
                start <= next_start;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (read_queue.size() == 0)
            begin
                $display("%0t: unexpected transaction result, expected none, actual %0d",
                         $realtime, read_data);
                errors++;
            end
            else
            begin
                got_exp = read_queue.pop_front();
                if (read_data !== got_exp.rdata)
                begin
                    $display({"%0t: read_data mismatch op=%0d pin=%0d wd=%0d",
                              " expected %0d actual %0d"},
                             $realtime, got_exp.cmd.op, got_exp.cmd.pin, got_exp.cmd.wdata,
                             got_exp.rdata, read_data);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= QUIET_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [7:0] hot_pins [12];
        logic [7:0] base;
        logic [7:0] p;
        logic [2:0] o;

        foreach (func_shadow[k]) func_shadow[k] = '0;
        foreach (pull_shadow[k]) pull_shadow[k] = '0;
        foreach (data_shadow[k]) data_shadow[k] = '0;

        // directed
        add_cmd(gpio_pcrb_pkg::OP_GET_FUNC, 8'd0,   3'd7);
        add_cmd(gpio_pcrb_pkg::OP_SET_FUNC, 8'd0,   3'd7);
        add_cmd(gpio_pcrb_pkg::OP_GET_FUNC, 8'd0,   3'd0);
        add_cmd(gpio_pcrb_pkg::OP_GET_FUNC, 8'd1,   3'd0);
        add_cmd(gpio_pcrb_pkg::OP_SET_FUNC, 8'd255, 3'd5);
        add_cmd(gpio_pcrb_pkg::OP_GET_FUNC, 8'd255, 3'd0);
        add_cmd(gpio_pcrb_pkg::OP_SET_PULL, 8'd255, 3'd7);
        add_cmd(gpio_pcrb_pkg::OP_GET_PULL, 8'd255, 3'd0);
        add_cmd(gpio_pcrb_pkg::OP_SET_PULL, 8'd16,  3'd2);
        add_cmd(gpio_pcrb_pkg::OP_GET_PULL, 8'd16,  3'd0);
        add_cmd(gpio_pcrb_pkg::OP_GET_PULL, 8'd0,   3'd0);
        add_cmd(gpio_pcrb_pkg::OP_SET_DATA, 8'd31,  3'd7);
        add_cmd(gpio_pcrb_pkg::OP_GET_DATA, 8'd31,  3'd0);
        add_cmd(gpio_pcrb_pkg::OP_SET_DATA, 8'd224, 3'd6);
        add_cmd(gpio_pcrb_pkg::OP_GET_DATA, 8'd224, 3'd0);
        add_cmd(gpio_pcrb_pkg::OP_SET_DATA, 8'd32,  3'd1);
        add_cmd(gpio_pcrb_pkg::OP_GET_DATA, 8'd32,  3'd0);
        add_cmd(OP_SPARE_6,                 8'd255, 3'd7);
        add_cmd(OP_SPARE_7,                 8'd0,   3'd7);
        add_cmd(gpio_pcrb_pkg::OP_GET_FUNC, 8'd255, 3'd0);
        add_cmd(gpio_pcrb_pkg::OP_SET_FUNC, 8'd0,   3'd0);
        add_cmd(gpio_pcrb_pkg::OP_GET_FUNC, 8'd0,   3'd0);
        add_cmd(gpio_pcrb_pkg::OP_GET_DATA, 8'd31,  3'd0);

        // random, mostly on a few pins so reads land on written fields
        for (int k = 0; k < 6; k++)
        begin
            base            = 8'($urandom_range(0, 255));
            hot_pins[2*k]   = base;
            hot_pins[2*k+1] = (k % 2 == 0) ? (base ^ 8'd1) : (base ^ 8'd16);
        end
        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            if ($urandom_range(0, 99) < 6)
                o = ($urandom_range(0, 1) == 1) ? OP_SPARE_7 : OP_SPARE_6;
            else
                o = 3'($urandom_range(gpio_pcrb_pkg::OP_SET_FUNC,
                                      gpio_pcrb_pkg::OP_GET_DATA));
            if ($urandom_range(0, 99) < 75)
                p = hot_pins[$urandom_range(0, 11)];
            else
                p = 8'($urandom_range(0, 255));
            add_cmd(o, p, 3'($urandom_range(0, 7)));
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        do @(negedge clk);
        while (cmd_queue.size() != 0 || start || read_queue.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
